// File: rtl/core/ppu_pkg.sv
// Package for the particle pool update engine: item types, codes,
// constants and the saturation helper. Depends on nothing.
`default_nettype none
package ppu_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] EMIT_MAX = 7'd64;

  // LCG and fixed-point constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;  // ceil(2^34 / 5)
  localparam logic [32:0] LIFE_BASE = 33'd50331648;  // 3 * 2^24
  localparam logic [32:0] JIT_BIAS = 33'd16777216;   // 2^24
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    REQ_EMIT  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  typedef enum logic [7:0] {
    CFG_RNG_SEED   = 8'd0,
    CFG_VEL_SPREAD = 8'd1,
    CFG_SIZE_BEGIN = 8'd2,
    CFG_SIZE_END   = 8'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] emit_pos_x;
    logic signed [31:0] emit_pos_y;
    logic signed [31:0] emit_pos_z;
    logic [6:0]         emit_count;
    logic signed [31:0] base_vel_x;
    logic signed [31:0] base_vel_y;
    logic signed [31:0] base_vel_z;
    logic signed [31:0] life_span;
    logic [30:0]        time_step;
  } req_t;

  typedef struct packed {
    logic signed [31:0] part_pos_x;
    logic signed [31:0] part_pos_y;
    logic signed [31:0] part_pos_z;
    logic signed [31:0] part_size;
    logic               has_particle;
    logic [6:0]         live_count;
    logic [6:0]         dropped_count;
    logic               is_last;
  } res_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [31:0] data;
  } cfg_t;

  // one stored particle
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life_left;
    logic signed [31:0] life_max;
    logic signed [31:0] size_start;
    logic signed [31:0] size_finish;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_E_CHECK, ST_E_LCG, ST_E_RAND, ST_E_MUL, ST_E_ACC, ST_E_SAVE,
    ST_T_RD, ST_T_GET, ST_T_MX, ST_T_MY, ST_T_MZ, ST_T_WR,
    ST_R_RD, ST_R_GET, ST_R_DIV, ST_R_SZ, ST_R_OUT,
    ST_PUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ppu_chan_if.sv
// Valid/ready channel carrying one payload item of type T.
// Used for request, result and configuration channels.
`default_nettype none
interface ppu_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ppu_store.sv
// Particle record memory: one write port, one registered read port.
// Depends on ppu_pkg for the record type.
`default_nettype none
module ppu_store #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  ppu_pkg::rec_t      wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output ppu_pkg::rec_t      rd_data
);
  import ppu_pkg::*;

  rec_t mem [DEPTH];

  // write record
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read record
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/core/ppu_mul.sv
// Shared 33x33 signed multiplier with registered product.
// Standalone; no package use.
`default_nettype none
module ppu_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      p
);
  // hold product until next issue
  always_ff @(posedge clk) begin
    if (en) p <= 66'(a) * 66'(b);
  end
endmodule
`default_nettype wire

// File: rtl/core/ppu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used for the life ratio on readout.
`default_nettype none
module ppu_div #(
  parameter int DW = 47,
  parameter int VW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot
);
  localparam int CW = $clog2(DW + 1);

  logic [VW:0]   rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem[VW-1:0], quot[DW-1]};
  assign fits = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift dividend through quotient, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      rem  <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quot <= {quot[DW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/particle_pool_update_engine.sv
// Particle pool update engine. Emit, tick and readout work one particle at
// a time; readout uses the divider for each particle that needs the life
// ratio. One item at a time, req ready only in idle.
// Reset (rst, synchronous) empties the pool, loads the register defaults
// and sets the generator to seed 0. Entries are read only below the fill count.
`default_nettype none
module particle_pool_update_engine #(
  parameter int MAX_PARTICLES = ppu_pkg::MAX_PARTICLES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ppu_chan_if.sink   req,
  ppu_chan_if.source res,
  ppu_chan_if.sink   cfg
);
  import ppu_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(MAX_PARTICLES);

  state_t state, state_next;

  req_t             rq;
  logic [CNT_W-1:0] cnt, idx, wpos, fill, dropped;
  logic [1:0]       axis;
  logic [31:0]      lcg;
  logic [30:0]      vel_spread;
  logic signed [31:0] size_begin, size_end;
  logic signed [31:0] vel [3];
  rec_t             cur;
  rec_t             fetched;
  logic [16:0]      t_frac;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               mul_en;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rec_t          wr_data, rd_data;

  logic          div_start, div_done;
  logic [46:0]   div_q;

  logic res_valid, res_load, out_free;
  res_t res_data, res_next;

  logic [23:0]        rnd;
  logic [32:0]        dt3;
  logic signed [31:0] vy_new, life_new;
  logic signed [31:0] base_sel;
  logic [16:0]        q_clamp;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.payload = res_data;
  assign out_free = !res_valid || res.ready;

  assign rnd = lcg[31:8];
  assign dt3 = {2'b00, rq.time_step} + {1'b0, rq.time_step, 1'b0};
  assign vy_new = sat32(67'(rd_data.vel_y) - 67'($signed({1'b0, dt3[32:1]})));
  assign life_new = sat32(67'(rd_data.life_left) - 67'($signed({1'b0, rq.time_step})));
  assign q_clamp = (div_q > 47'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];

  always_comb begin
    unique case (axis)
      2'd0:    base_sel = rq.base_vel_x;
      2'd1:    base_sel = rq.base_vel_y;
      default: base_sel = rq.base_vel_z;
    endcase
  end

  // fold the tick update into the fetched record
  always_comb begin
    fetched = rd_data;
    if (state == ST_T_GET) begin
      fetched.vel_y = vy_new;
      fetched.life_left = life_new;
    end
  end

  ppu_store #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  ppu_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(prod));

  ppu_div #(.DW(47), .VW(31)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({rd_data.life_left[30:0], 16'd0}),
    .divisor(rd_data.life_max[30:0]),
    .done(div_done), .quot(div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state, unit operands and memory control
  always_comb begin
    state_next = state;
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    wr_en = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = cur;
    rd_en = 1'b0;
    rd_addr = idx[AW-1:0];
    div_start = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    res_next.live_count = fill;
    res_next.is_last = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          unique case (req.payload.req_type)
            REQ_EMIT:  state_next = ST_E_CHECK;
            REQ_TICK:  state_next = ST_T_RD;
            REQ_READ:  state_next = (fill == '0) ? ST_PUT : ST_R_RD;
            default:   state_next = ST_PUT;
          endcase
        end
      end
      ST_E_CHECK: begin
        if (idx == cnt) state_next = ST_PUT;
        else if (fill < POOL_MAX) state_next = ST_E_LCG;
      end
      ST_E_LCG: begin
        mul_en = 1'b1;
        mul_a = $signed({1'b0, lcg});
        mul_b = $signed({1'b0, LCG_MUL});
        state_next = ST_E_RAND;
      end
      ST_E_RAND: state_next = ST_E_MUL;
      ST_E_MUL: begin
        mul_en = 1'b1;
        if (axis != 2'd3) begin
          mul_a = $signed({8'd0, rnd, 1'b0} - JIT_BIAS);
          mul_b = $signed({2'b00, vel_spread});
        end else begin
          mul_a = $signed(LIFE_BASE + {8'd0, rnd, 1'b0});
          mul_b = $signed({1'b0, RECIP5});
        end
        state_next = ST_E_ACC;
      end
      ST_E_ACC: begin
        if (axis != 2'd3) begin
          state_next = ST_E_LCG;
        end else begin
          // life factor is the quotient by five, now scale the life span
          mul_en = 1'b1;
          mul_a = 33'(rq.life_span);
          mul_b = $signed({8'd0, prod[58:34]});
          state_next = ST_E_SAVE;
        end
      end
      ST_E_SAVE: begin
        wr_en = 1'b1;
        wr_addr = fill[AW-1:0];
        wr_data.pos_x = rq.emit_pos_x;
        wr_data.pos_y = rq.emit_pos_y;
        wr_data.pos_z = rq.emit_pos_z;
        wr_data.vel_x = vel[0];
        wr_data.vel_y = vel[1];
        wr_data.vel_z = vel[2];
        wr_data.life_max = sat32(67'(prod >>> 24));
        wr_data.life_left = sat32(67'(prod >>> 24));
        wr_data.size_start = size_begin;
        wr_data.size_finish = size_end;
        state_next = ST_E_CHECK;
      end
      ST_T_RD: begin
        if (idx == fill) begin
          state_next = ST_PUT;
        end else begin
          rd_en = 1'b1;
          state_next = ST_T_GET;
        end
      end
      ST_T_GET: state_next = (life_new <= 0) ? ST_T_RD : ST_T_MX;
      ST_T_MX: begin
        mul_en = 1'b1;
        mul_a = 33'(cur.vel_x);
        mul_b = $signed({2'b00, rq.time_step});
        state_next = ST_T_MY;
      end
      ST_T_MY: begin
        mul_en = 1'b1;
        mul_a = 33'(cur.vel_y);
        mul_b = $signed({2'b00, rq.time_step});
        state_next = ST_T_MZ;
      end
      ST_T_MZ: begin
        mul_en = 1'b1;
        mul_a = 33'(cur.vel_z);
        mul_b = $signed({2'b00, rq.time_step});
        state_next = ST_T_WR;
      end
      ST_T_WR: begin
        wr_en = 1'b1;
        wr_addr = wpos[AW-1:0];
        wr_data.pos_z = sat32(67'(cur.pos_z) + 67'(prod >>> 16));
        state_next = ST_T_RD;
      end
      ST_R_RD: begin
        rd_en = 1'b1;
        state_next = ST_R_GET;
      end
      ST_R_GET: begin
        if (rd_data.life_max <= 0 || rd_data.life_left <= 0) begin
          state_next = ST_R_SZ;
        end else begin
          div_start = 1'b1;
          state_next = ST_R_DIV;
        end
      end
      ST_R_DIV: if (div_done) state_next = ST_R_SZ;
      ST_R_SZ: begin
        mul_en = 1'b1;
        mul_a = 33'(cur.size_finish) - 33'(cur.size_start);
        mul_b = $signed({16'd0, t_frac});
        state_next = ST_R_OUT;
      end
      ST_R_OUT: begin
        res_next.part_pos_x = cur.pos_x;
        res_next.part_pos_y = cur.pos_y;
        res_next.part_pos_z = cur.pos_z;
        res_next.part_size = sat32(67'(cur.size_start) + 67'(prod >>> 16));
        res_next.has_particle = 1'b1;
        res_next.is_last = (idx + 1'b1 == fill);
        if (out_free) begin
          res_load = 1'b1;
          state_next = (idx + 1'b1 == fill) ? ST_IDLE : ST_R_RD;
        end
      end
      ST_PUT: begin
        res_next.dropped_count = dropped;
        if (out_free) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers: counters, fill, generator, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      lcg        <= '0;
      vel_spread <= 31'd65536;
      size_begin <= 32'sd65536;
      size_end   <= 32'sd0;
      idx        <= '0;
      wpos       <= '0;
      cnt        <= '0;
      dropped    <= '0;
      axis       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx     <= '0;
          wpos    <= '0;
          dropped <= '0;
          cnt     <= (req.payload.emit_count > EMIT_MAX) ? EMIT_MAX : req.payload.emit_count;
          if (req.valid && req.payload.req_type == REQ_CLEAR) fill <= '0;
        end
        ST_E_CHECK: begin
          axis <= '0;
          if (idx != cnt && fill >= POOL_MAX) begin
            dropped <= dropped + 1'b1;
            idx     <= idx + 1'b1;
          end
        end
        ST_E_RAND: lcg <= prod[31:0] + LCG_ADD;
        ST_E_ACC:  axis <= axis + 1'b1;
        ST_E_SAVE: begin
          fill <= fill + 1'b1;
          idx  <= idx + 1'b1;
        end
        ST_T_RD: if (idx == fill) fill <= wpos;
        ST_T_GET: if (life_new <= 0) idx <= idx + 1'b1;
        ST_T_WR: begin
          wpos <= wpos + 1'b1;
          idx  <= idx + 1'b1;
        end
        ST_R_OUT: if (out_free) idx <= idx + 1'b1;
        default: ;
      endcase
      // configuration is to be written only while idle; the block does not enforce it
      if (cfg.valid) begin
        unique case (cfg.payload.addr)
          CFG_RNG_SEED:   lcg <= cfg.payload.data;
          CFG_VEL_SPREAD: vel_spread <= cfg.payload.data[30:0];
          CFG_SIZE_BEGIN: size_begin <= cfg.payload.data;
          CFG_SIZE_END:   size_end <= cfg.payload.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) rq <= req.payload;
    if (state == ST_E_ACC && axis != 2'd3) begin
      vel[axis] <= sat32(67'(base_sel) + 67'(prod >>> 24));
    end
    if (state == ST_T_GET || state == ST_R_GET) cur <= fetched;
    if (state == ST_T_MY) cur.pos_x <= sat32(67'(cur.pos_x) + 67'(prod >>> 16));
    if (state == ST_T_MZ) cur.pos_y <= sat32(67'(cur.pos_y) + 67'(prod >>> 16));
    if (state == ST_R_GET) t_frac <= ONE_Q16;
    if (state == ST_R_DIV && div_done) t_frac <= ONE_Q16 - q_clamp;
    if (res_load) res_data <= res_next;
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (res.ready) res_valid <= 1'b0;
  end
endmodule
`default_nettype wire

// File: rtl/core/ppu_checker.sv
// Port-level checks for the particle pool update engine, bound to its top.
// Depends on ppu_pkg for the default pool size.
`default_nettype none
module ppu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       has_particle,
  input wire logic       is_last,
  input wire logic [6:0] live_count,
  input wire logic [6:0] dropped_count,
  input wire logic [31:0] part_size
);
  import ppu_pkg::*;

  // stalled item stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped while stalled");

  // summary items always close their request
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_particle |-> is_last) else $error("summary item not last");

  // pool never reports more than the default pool size
  a_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> live_count <= 7'(MAX_PARTICLES_DEF)) else $error("live count too big");

  // particle items carry no drop count, summaries no size
  a_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && has_particle |-> dropped_count == 7'd0) else $error("drop on readout");

  a_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_particle |-> part_size == 32'd0) else $error("size on summary");
endmodule

bind particle_pool_update_engine ppu_checker u_ppu_checker (
  .clk(clk), .rst(rst),
  .res_valid(res.valid), .res_ready(res.ready),
  .has_particle(res.payload.has_particle), .is_last(res.payload.is_last),
  .live_count(res.payload.live_count), .dropped_count(res.payload.dropped_count),
  .part_size(res.payload.part_size)
);
`default_nettype wire
